// ===== sv/cst_pkg.sv =====
// shared types, constants and lookup functions for the token scanner
package cst_pkg;

   // default sizes
   localparam int CST_PREFIX_DEPTH     = 8;
   localparam int CST_MAX_TOKEN_LENGTH = 255;
   localparam int CST_RSP_DEPTH        = 4;

   // longest keyword, in characters
   localparam int KW_SPAN = 7;
   localparam int KW_COUNT = 15;

   // characters with a role of their own
   localparam logic [7:0] CHR_SQUOTE = 8'd39;
   localparam logic [7:0] CHR_DQUOTE = 8'd34;
   localparam logic [7:0] CHR_DOT    = ".";
   localparam logic [7:0] CHR_EQ     = "=";
   localparam logic [7:0] CHR_PLUS   = "+";
   localparam logic [7:0] CHR_MINUS  = "-";

   // operator and delimiter indexes
   localparam logic [4:0] OP_LE     = 5'd0;
   localparam logic [4:0] OP_GE     = 5'd1;
   localparam logic [4:0] OP_EQEQ   = 5'd2;
   localparam logic [4:0] OP_ASSIGN = 5'd3;
   localparam logic [4:0] OP_GT     = 5'd4;
   localparam logic [4:0] OP_LT     = 5'd5;
   localparam logic [4:0] OP_ADD    = 5'd6;
   localparam logic [4:0] OP_INC    = 5'd7;
   localparam logic [4:0] OP_ADDEQ  = 5'd8;
   localparam logic [4:0] OP_SUB    = 5'd9;
   localparam logic [4:0] OP_DEC    = 5'd10;
   localparam logic [4:0] OP_SUBEQ  = 5'd11;
   localparam logic [4:0] OP_MUL    = 5'd12;
   localparam logic [4:0] OP_MULEQ  = 5'd13;
   localparam logic [4:0] OP_DIV    = 5'd14;
   localparam logic [4:0] OP_DIVEQ  = 5'd15;
   localparam logic [4:0] OP_LBRACE = 5'd16;
   localparam logic [4:0] OP_RBRACE = 5'd17;
   localparam logic [4:0] OP_LPAREN = 5'd18;
   localparam logic [4:0] OP_RPAREN = 5'd19;
   localparam logic [4:0] OP_LBRACK = 5'd20;
   localparam logic [4:0] OP_RBRACK = 5'd21;
   localparam logic [4:0] OP_COMMA  = 5'd22;
   localparam logic [4:0] OP_SEMI   = 5'd23;

   // pending operator kinds, by lead character
   localparam logic [2:0] OPK_EQ    = 3'd0;
   localparam logic [2:0] OPK_GT    = 3'd1;
   localparam logic [2:0] OPK_LT    = 3'd2;
   localparam logic [2:0] OPK_PLUS  = 3'd3;
   localparam logic [2:0] OPK_MINUS = 3'd4;
   localparam logic [2:0] OPK_STAR  = 3'd5;
   localparam logic [2:0] OPK_SLASH = 3'd6;

   typedef enum logic [2:0] {
      CL_KEY = 3'd0,
      CL_ID  = 3'd1,
      CL_OP  = 3'd2,
      CL_NUM = 3'd3,
      CL_CHR = 3'd4,
      CL_STR = 3'd5,
      CL_ERR = 3'd6
   } cst_class_type;

   typedef enum logic [7:0] {
      ST_START = 8'b0000_0001,
      ST_WORD  = 8'b0000_0010,
      ST_INT   = 8'b0000_0100,
      ST_DOT   = 8'b0000_1000,
      ST_FRAC  = 8'b0001_0000,
      ST_CHR   = 8'b0010_0000,
      ST_STR   = 8'b0100_0000,
      ST_OP    = 8'b1000_0000
   } cst_scan_type;

   typedef struct packed {
      logic [2:0] token_class;
      logic [4:0] token_index;
      logic [7:0] token_length;
      logic       last_of_run;
   } cst_result_type;

   // results of one character, oldest in word[0]
   typedef struct packed {
      logic [1:0]                count;
      cst_result_type [1:0]      word;
   } cst_rsp_pair_type;

   typedef struct packed {
      logic       hit;
      logic [3:0] idx;
   } cst_kw_type;

   typedef struct packed {
      logic       hit;
      logic [2:0] kind;
   } cst_lead_type;

   typedef struct packed {
      logic       hit;
      logic [4:0] idx;
   } cst_delim_type;

   function automatic logic is_letter(input logic [7:0] c);
      return c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
   endfunction

   function automatic logic is_numeral(input logic [7:0] c);
      return c inside {[8'h30:8'h39]};
   endfunction

   // keyword text, first character in the top byte
   function automatic logic [55:0] kw_text(input logic [3:0] k);
      logic [55:0] t;
      case (k)
         4'd0:    t = {"int", 32'd0};
         4'd1:    t = {"main", 24'd0};
         4'd2:    t = {"void", 24'd0};
         4'd3:    t = {"if", 40'd0};
         4'd4:    t = {"else", 24'd0};
         4'd5:    t = {"char", 24'd0};
         4'd6:    t = {"float", 16'd0};
         4'd7:    t = {"double", 8'd0};
         4'd8:    t = {"for", 32'd0};
         4'd9:    t = {"while", 16'd0};
         4'd10:   t = {"break", 16'd0};
         4'd11:   t = {"switch", 8'd0};
         4'd12:   t = {"case", 24'd0};
         4'd13:   t = "default";
         4'd14:   t = {"return", 8'd0};
         default: t = 56'd0;
      endcase
      return t;
   endfunction

   function automatic int kw_len(input logic [3:0] k);
      int l;
      case (k)
         4'd0, 4'd8:                          l = 3;
         4'd1, 4'd2, 4'd4, 4'd5, 4'd12:       l = 4;
         4'd3:                                l = 2;
         4'd6, 4'd9, 4'd10:                   l = 5;
         4'd7, 4'd11, 4'd14:                  l = 6;
         4'd13:                               l = 7;
         default:                             l = 0;
      endcase
      return l;
   endfunction

   // compare the stored word against every keyword in parallel
   function automatic cst_kw_type kw_lookup(input logic [55:0] w, input logic [15:0] len);
      cst_kw_type r;
      logic [55:0] t;
      int          l;
      r = '0;
      for (int k = 0; k < KW_COUNT; k++) begin
         t = kw_text(4'(k));
         l = kw_len(4'(k));
         if (!r.hit && len == 16'(l) && ((w ^ t) >> (8 * (KW_SPAN - l))) == 56'd0) begin
            r.hit = 1'b1;
            r.idx = 4'(k);
         end
      end
      return r;
   endfunction

   function automatic cst_lead_type op_lead(input logic [7:0] c);
      cst_lead_type r;
      r.hit = 1'b1;
      case (c)
         "=":     r.kind = OPK_EQ;
         ">":     r.kind = OPK_GT;
         "<":     r.kind = OPK_LT;
         "+":     r.kind = OPK_PLUS;
         "-":     r.kind = OPK_MINUS;
         "*":     r.kind = OPK_STAR;
         "/":     r.kind = OPK_SLASH;
         default: begin
            r.hit  = 1'b0;
            r.kind = OPK_EQ;
         end
      endcase
      return r;
   endfunction

   function automatic cst_delim_type delim_lookup(input logic [7:0] c);
      cst_delim_type r;
      r.hit = 1'b1;
      case (c)
         "{":     r.idx = OP_LBRACE;
         "}":     r.idx = OP_RBRACE;
         "(":     r.idx = OP_LPAREN;
         ")":     r.idx = OP_RPAREN;
         "[":     r.idx = OP_LBRACK;
         "]":     r.idx = OP_RBRACK;
         ",":     r.idx = OP_COMMA;
         ";":     r.idx = OP_SEMI;
         default: begin
            r.hit = 1'b0;
            r.idx = OP_LE;
         end
      endcase
      return r;
   endfunction

   // index of an operator that stays one character long
   function automatic logic [4:0] op_single(input logic [2:0] kind);
      logic [4:0] r;
      case (kind)
         OPK_EQ:    r = OP_ASSIGN;
         OPK_GT:    r = OP_GT;
         OPK_LT:    r = OP_LT;
         OPK_PLUS:  r = OP_ADD;
         OPK_MINUS: r = OP_SUB;
         OPK_STAR:  r = OP_MUL;
         OPK_SLASH: r = OP_DIV;
         default:   r = OP_ASSIGN;
      endcase
      return r;
   endfunction

   // first follow character of each lead
   function automatic logic [7:0] op_f1_char(input logic [2:0] kind);
      logic [7:0] r;
      case (kind)
         OPK_PLUS:  r = CHR_PLUS;
         OPK_MINUS: r = CHR_MINUS;
         default:   r = CHR_EQ;
      endcase
      return r;
   endfunction

   function automatic logic [4:0] op_f1_idx(input logic [2:0] kind);
      logic [4:0] r;
      case (kind)
         OPK_EQ:    r = OP_EQEQ;
         OPK_GT:    r = OP_GE;
         OPK_LT:    r = OP_LE;
         OPK_PLUS:  r = OP_INC;
         OPK_MINUS: r = OP_DEC;
         OPK_STAR:  r = OP_MULEQ;
         OPK_SLASH: r = OP_DIVEQ;
         default:   r = OP_EQEQ;
      endcase
      return r;
   endfunction

   // plus and minus also take a trailing equals sign
   function automatic logic op_f2_has(input logic [2:0] kind);
      return kind == OPK_PLUS || kind == OPK_MINUS;
   endfunction

   function automatic logic [4:0] op_f2_idx(input logic [2:0] kind);
      return (kind == OPK_PLUS) ? OP_ADDEQ : OP_SUBEQ;
   endfunction

   function automatic logic [7:0] sat_length(input logic [15:0] v);
      return (v > 16'd255) ? 8'hFF : v[7:0];
   endfunction

   function automatic cst_result_type make_result(input cst_class_type cls,
                                                  input logic [4:0] idx,
                                                  input logic [15:0] len);
      cst_result_type r;
      r.token_class  = cls;
      r.token_index  = idx;
      r.token_length = sat_length(len);
      r.last_of_run  = 1'b0;
      return r;
   endfunction

endpackage

// ===== sv/cst_channels.sv =====
// valid/ready channel interfaces for characters in and tokens out
interface cst_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_in;
   logic       end_of_input;

   modport source (output valid, output char_in, output end_of_input, input ready);
   modport sink   (input valid, input char_in, input end_of_input, output ready);
endinterface

interface cst_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] token_class;
   logic [4:0] token_index;
   logic [7:0] token_length;
   logic       last_of_run;

   modport source (output valid, output token_class, output token_index,
                   output token_length, output last_of_run, input ready);
   modport sink   (input valid, input token_class, input token_index,
                   input token_length, input last_of_run, output ready);
endinterface

// ===== sv/cst_step.sv =====
// one lexer step: pending state, rescan from start, end-of-input flush
module cst_step
   import cst_pkg::*;
#(
   parameter int PREFIX_DEPTH     = CST_PREFIX_DEPTH,
   parameter int MAX_TOKEN_LENGTH = CST_MAX_TOKEN_LENGTH,
   localparam int LEN_W  = $clog2(MAX_TOKEN_LENGTH + 1),
   localparam int PIDX_W = $clog2(PREFIX_DEPTH)
) (
   input  cst_scan_type                     scan_state,
   input  logic [2:0]                       op_kind,
   input  logic [LEN_W-1:0]                 length,
   input  logic [PREFIX_DEPTH-1:0][7:0]     prefix,
   input  logic                             error_flag,
   input  logic [7:0]                       char_in,
   input  logic                             end_of_input,
   output cst_scan_type                     scan_next,
   output logic [2:0]                       op_kind_next,
   output logic [LEN_W-1:0]                 length_next,
   output logic                             error_next,
   output logic                             prefix_we,
   output logic [PIDX_W-1:0]                prefix_idx,
   output cst_rsp_pair_type                 rsp_pair
);

   cst_scan_type      s_mid;
   logic [2:0]        k_mid;
   logic [LEN_W-1:0]  len_mid;
   logic [LEN_W-1:0]  len_inc;
   logic              err_mid;
   logic              take_ok;
   logic              again;
   logic              pend_v;
   logic              start_v;
   logic              flush_v;
   cst_result_type    pend_r;
   cst_result_type    start_r;
   cst_result_type    flush_r;
   cst_result_type    r0;
   cst_result_type    r1;
   logic [1:0]        count;
   logic [55:0]       word_now;
   logic [55:0]       word_upd;
   cst_kw_type        kw_now;
   cst_kw_type        kw_upd;
   cst_lead_type      lead;
   cst_delim_type     dlm;
   logic              alnum;
   logic              digit;

   // length after taking one more character, saturating
   assign len_inc = (length < LEN_W'(MAX_TOKEN_LENGTH)) ? length + LEN_W'(1) : length;
   assign take_ok = {1'b0, length} < (LEN_W + 1)'(PREFIX_DEPTH);

   assign lead  = op_lead(char_in);
   assign dlm   = delim_lookup(char_in);
   assign digit = is_numeral(char_in);
   assign alnum = is_letter(char_in) || digit;

   // keyword lookup on the stored prefix
   always_comb begin
      for (int i = 0; i < KW_SPAN; i++) begin
         word_now[8*(KW_SPAN-1-i) +: 8] = prefix[i];
      end
   end

   // and on the prefix after this write
   always_comb begin
      for (int i = 0; i < KW_SPAN; i++) begin
         word_upd[8*(KW_SPAN-1-i) +: 8] =
            (prefix_we && prefix_idx == PIDX_W'(i)) ? char_in : prefix[i];
      end
   end

   assign kw_now = kw_lookup(word_now, 16'(length));
   assign kw_upd = kw_lookup(word_upd, 16'(len_mid));

   // pending token, then the start state for a character that closed it
   always_comb begin
      s_mid      = scan_state;
      k_mid      = op_kind;
      len_mid    = length;
      err_mid    = error_flag;
      prefix_we  = 1'b0;
      prefix_idx = '0;
      again      = 1'b0;
      pend_v     = 1'b0;
      pend_r     = '0;
      start_v    = 1'b0;
      start_r    = '0;
      if (!error_flag) begin
         case (scan_state)
            ST_START: begin
               again = 1'b1;
            end
            ST_WORD: begin
               if (alnum) begin
                  prefix_we  = take_ok;
                  prefix_idx = length[PIDX_W-1:0];
                  len_mid    = len_inc;
               end else begin
                  pend_v  = 1'b1;
                  pend_r  = kw_now.hit ?
                            make_result(CL_KEY, {1'b0, kw_now.idx}, 16'(length)) :
                            make_result(CL_ID, 5'd0, 16'(length));
                  s_mid   = ST_START;
                  len_mid = '0;
                  again   = 1'b1;
               end
            end
            ST_INT: begin
               if (digit || char_in == CHR_DOT) begin
                  prefix_we  = take_ok;
                  prefix_idx = length[PIDX_W-1:0];
                  len_mid    = len_inc;
                  if (!digit) begin
                     s_mid = ST_DOT;
                  end
               end else begin
                  pend_v  = 1'b1;
                  pend_r  = make_result(CL_NUM, 5'd0, 16'(length));
                  s_mid   = ST_START;
                  len_mid = '0;
                  again   = 1'b1;
               end
            end
            ST_DOT: begin
               if (digit) begin
                  prefix_we  = take_ok;
                  prefix_idx = length[PIDX_W-1:0];
                  len_mid    = len_inc;
                  s_mid      = ST_FRAC;
               end else begin
                  // dot with no digit after it: error, character dropped
                  err_mid = 1'b1;
                  pend_v  = 1'b1;
                  pend_r  = make_result(CL_ERR, 5'd0, 16'(length));
                  s_mid   = ST_START;
                  len_mid = '0;
               end
            end
            ST_FRAC: begin
               if (digit) begin
                  prefix_we  = take_ok;
                  prefix_idx = length[PIDX_W-1:0];
                  len_mid    = len_inc;
               end else begin
                  pend_v  = 1'b1;
                  pend_r  = make_result(CL_NUM, 5'd0, 16'(length));
                  s_mid   = ST_START;
                  len_mid = '0;
                  again   = 1'b1;
               end
            end
            ST_CHR, ST_STR: begin
               prefix_we  = take_ok;
               prefix_idx = length[PIDX_W-1:0];
               len_mid    = len_inc;
               if (scan_state == ST_CHR && char_in == CHR_SQUOTE) begin
                  pend_v  = 1'b1;
                  pend_r  = make_result(CL_CHR, 5'd0, 16'(len_inc));
                  s_mid   = ST_START;
                  len_mid = '0;
               end else if (scan_state == ST_STR && char_in == CHR_DQUOTE) begin
                  pend_v  = 1'b1;
                  pend_r  = make_result(CL_STR, 5'd0, 16'(len_inc));
                  s_mid   = ST_START;
                  len_mid = '0;
               end
            end
            ST_OP: begin
               if (char_in == op_f1_char(op_kind)) begin
                  prefix_we  = take_ok;
                  prefix_idx = length[PIDX_W-1:0];
                  pend_v     = 1'b1;
                  pend_r     = make_result(CL_OP, op_f1_idx(op_kind), 16'(len_inc));
               end else if (op_f2_has(op_kind) && char_in == CHR_EQ) begin
                  prefix_we  = take_ok;
                  prefix_idx = length[PIDX_W-1:0];
                  pend_v     = 1'b1;
                  pend_r     = make_result(CL_OP, op_f2_idx(op_kind), 16'(len_inc));
               end else begin
                  pend_v = 1'b1;
                  pend_r = make_result(CL_OP, op_single(op_kind), 16'(length));
                  again  = 1'b1;
               end
               s_mid   = ST_START;
               len_mid = '0;
            end
            default: begin
               s_mid   = ST_START;
               len_mid = '0;
               again   = 1'b1;
            end
         endcase

         // scan the character from the start state
         if (again) begin
            if (is_letter(char_in) || digit || char_in == CHR_SQUOTE ||
                char_in == CHR_DQUOTE || lead.hit || dlm.hit) begin
               prefix_we  = 1'b1;
               prefix_idx = '0;
               len_mid    = LEN_W'(1);
            end
            if (is_letter(char_in)) begin
               s_mid = ST_WORD;
            end else if (digit) begin
               s_mid = ST_INT;
            end else if (char_in == CHR_SQUOTE) begin
               s_mid = ST_CHR;
            end else if (char_in == CHR_DQUOTE) begin
               s_mid = ST_STR;
            end else if (lead.hit) begin
               s_mid = ST_OP;
               k_mid = lead.kind;
            end else if (dlm.hit) begin
               start_v = 1'b1;
               start_r = make_result(CL_OP, dlm.idx, 16'd1);
               s_mid   = ST_START;
               len_mid = '0;
            end
         end
      end
   end

   // end of input: flush whatever token is still open
   always_comb begin
      scan_next    = s_mid;
      op_kind_next = k_mid;
      length_next  = len_mid;
      error_next   = err_mid;
      flush_v      = 1'b0;
      flush_r      = '0;
      if (end_of_input && !error_flag) begin
         if (!err_mid) begin
            case (s_mid)
               ST_START: begin
                  flush_v = 1'b0;
               end
               ST_WORD: begin
                  flush_v = 1'b1;
                  flush_r = kw_upd.hit ?
                            make_result(CL_KEY, {1'b0, kw_upd.idx}, 16'(len_mid)) :
                            make_result(CL_ID, 5'd0, 16'(len_mid));
               end
               ST_INT, ST_FRAC: begin
                  flush_v = 1'b1;
                  flush_r = make_result(CL_NUM, 5'd0, 16'(len_mid));
               end
               ST_OP: begin
                  flush_v = 1'b1;
                  flush_r = make_result(CL_OP, op_single(k_mid), 16'(len_mid));
               end
               default: begin
                  // open quote or trailing dot
                  error_next = 1'b1;
                  flush_v    = 1'b1;
                  flush_r    = make_result(CL_ERR, 5'd0, 16'(len_mid));
               end
            endcase
         end
         scan_next   = ST_START;
         length_next = '0;
      end
   end

   // pack up to two results in order and mark the last one
   always_comb begin
      count = {1'b0, pend_v} + {1'b0, start_v} + {1'b0, flush_v};
      r0    = pend_v ? pend_r : (start_v ? start_r : flush_r);
      r1    = (pend_v && start_v) ? start_r : flush_r;
      if (count == 2'd1) begin
         r0.last_of_run = 1'b1;
      end
      if (count == 2'd2) begin
         r1.last_of_run = 1'b1;
      end
      rsp_pair.count   = count;
      rsp_pair.word[0] = r0;
      rsp_pair.word[1] = r1;
   end

endmodule

// ===== sv/cst_rsp_fifo.sv =====
// small result queue that takes up to two words a cycle and sends one while rsp_chan.ready is high
module cst_rsp_fifo
   import cst_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic [1:0]         push_count,
   input  cst_rsp_pair_type   push_data,
   output logic               room,
   cst_rsp_if.source          rsp_chan
);

   localparam int DEPTH = CST_RSP_DEPTH;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   cst_result_type     mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_in;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;
   logic               pop;

   // head of queue drives the channel
   assign rsp_chan.valid        = count_ff != '0;
   assign rsp_chan.token_class  = mem_ff[rd_ptr_ff].token_class;
   assign rsp_chan.token_index  = mem_ff[rd_ptr_ff].token_index;
   assign rsp_chan.token_length = mem_ff[rd_ptr_ff].token_length;
   assign rsp_chan.last_of_run  = mem_ff[rd_ptr_ff].last_of_run;

   assign pop  = rsp_chan.valid && rsp_chan.ready;
   assign room = count_ff <= CNT_W'(DEPTH - 2);

   // pointer and fill bookkeeping
   assign wr_ptr_in = wr_ptr_ff + PTR_W'(push_count);
   assign rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
   assign count_in  = count_ff + CNT_W'(push_count) - CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage writes
   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push_data.word[0];
      end
      if (push_count == 2'd2) begin
         mem_ff[wr_ptr_ff + PTR_W'(1)] <= push_data.word[1];
      end
   end

endmodule

// ===== sv/c_subset_token_scanner.sv =====
// top level of the token scanner: scan state registers, step logic, result queue
//
//   channel   dir   payload                                            word accepted
//   req_chan  in    char_in, end_of_input                              valid && ready
//   rsp_chan  out   token_class, token_index, token_length, last_of_run valid && ready
//
// One character is accepted per cycle; its step logic runs in the cycle it is taken
// and its zero, one or two result words land in a four-word queue.
// The queue sets the rate: req_chan.ready is high while two words are free, so a
// stream that makes one token per character runs at one character a cycle.
// Synchronous reset puts the scanner in the start state and empties the queue.
// A stall on rsp_chan fills the queue and then holds req_chan.ready low.
module c_subset_token_scanner
   import cst_pkg::*;
#(
   parameter int PREFIX_DEPTH     = CST_PREFIX_DEPTH,
   parameter int MAX_TOKEN_LENGTH = CST_MAX_TOKEN_LENGTH
) (
   input  logic       clock,
   input  logic       reset,
   cst_req_if.sink    req_chan,
   cst_rsp_if.source  rsp_chan
);

   localparam int LEN_W  = $clog2(MAX_TOKEN_LENGTH + 1);
   localparam int PIDX_W = $clog2(PREFIX_DEPTH);

   cst_scan_type                  scan_ff;
   cst_scan_type                  scan_in;
   logic [2:0]                    op_kind_ff;
   logic [2:0]                    op_kind_in;
   logic [LEN_W-1:0]              length_ff;
   logic [LEN_W-1:0]              length_in;
   logic                          error_ff;
   logic                          error_in;
   logic [PREFIX_DEPTH-1:0][7:0]  prefix_ff;
   logic                          prefix_we;
   logic [PIDX_W-1:0]             prefix_idx;
   cst_rsp_pair_type              rsp_pair;
   logic                          room;
   logic                          accept;
   logic [1:0]                    push_count;

   assign req_chan.ready = room;
   assign accept         = req_chan.valid && req_chan.ready;
   assign push_count     = accept ? rsp_pair.count : 2'd0;

   // lexer step for the offered character
   cst_step #(
      .PREFIX_DEPTH     (PREFIX_DEPTH),
      .MAX_TOKEN_LENGTH (MAX_TOKEN_LENGTH)
   ) u_step (
      .scan_state   (scan_ff),
      .op_kind      (op_kind_ff),
      .length       (length_ff),
      .prefix       (prefix_ff),
      .error_flag   (error_ff),
      .char_in      (req_chan.char_in),
      .end_of_input (req_chan.end_of_input),
      .scan_next    (scan_in),
      .op_kind_next (op_kind_in),
      .length_next  (length_in),
      .error_next   (error_in),
      .prefix_we    (prefix_we),
      .prefix_idx   (prefix_idx),
      .rsp_pair     (rsp_pair)
   );

   // scan state, updated on every accepted word
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff    <= ST_START;
         op_kind_ff <= OPK_EQ;
         length_ff  <= '0;
         error_ff   <= 1'b0;
      end else if (accept) begin
         scan_ff    <= scan_in;
         op_kind_ff <= op_kind_in;
         length_ff  <= length_in;
         error_ff   <= error_in;
      end
   end

   // first characters of the open token
   always_ff @(posedge clock) begin
      if (accept && prefix_we) begin
         prefix_ff[prefix_idx] <= req_chan.char_in;
      end
   end

   // result queue
   cst_rsp_fifo u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_count (push_count),
      .push_data  (rsp_pair),
      .room       (room),
      .rsp_chan   (rsp_chan)
   );

endmodule

// ===== tb/sv/cst_token_checker.sv =====
// token scanner scoreboard: predicts every token word and compares it with the result channel
module cst_token_checker
   import cst_pkg::*;
(
   input  logic clock,
   input  logic reset,
   cst_req_if   req_mon,
   cst_rsp_if   rsp_mon,
   output int   fail_count,
   output int   tokens_waiting,
   output int   tokens_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PFX_DEPTH = CST_PREFIX_DEPTH;
   localparam int LEN_LIMIT = CST_MAX_TOKEN_LENGTH;
   localparam int REPORT_MAX = 10;

   // scanner model state
   cst_scan_type   scan_st = ST_START;
   logic [2:0]     op_kind = OPK_EQ;
   logic [7:0]     prefix [PFX_DEPTH];
   int             tok_len = 0;
   bit             err_sticky = 1'b0;

   // words of the current character, and words still owed by the block
   cst_result_type char_words [$];
   cst_result_type token_q [$];

   int misses = 0;
   int checked = 0;
   int waiting = 0;

   assign fail_count     = misses;
   assign tokens_waiting = waiting;
   assign tokens_checked = checked;

   function automatic bit letter_char(input logic [7:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
   endfunction

   function automatic bit digit_char(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic string keyword_spelling(input int k);
      case (k)
         0:       return "int";
         1:       return "main";
         2:       return "void";
         3:       return "if";
         4:       return "else";
         5:       return "char";
         6:       return "float";
         7:       return "double";
         8:       return "for";
         9:       return "while";
         10:      return "break";
         11:      return "switch";
         12:      return "case";
         13:      return "default";
         default: return "return";
      endcase
   endfunction

   function automatic int delim_index(input logic [7:0] c);
      case (c)
         "{":     return OP_LBRACE;
         "}":     return OP_RBRACE;
         "(":     return OP_LPAREN;
         ")":     return OP_RPAREN;
         "[":     return OP_LBRACK;
         "]":     return OP_RBRACK;
         ",":     return OP_COMMA;
         ";":     return OP_SEMI;
         default: return -1;
      endcase
   endfunction

   function automatic int lead_kind(input logic [7:0] c);
      case (c)
         "=":     return OPK_EQ;
         ">":     return OPK_GT;
         "<":     return OPK_LT;
         "+":     return OPK_PLUS;
         "-":     return OPK_MINUS;
         "*":     return OPK_STAR;
         "/":     return OPK_SLASH;
         default: return -1;
      endcase
   endfunction

   // index of a lone operator character
   function automatic logic [4:0] solo_index(input logic [2:0] kind);
      case (kind)
         OPK_EQ:    return OP_ASSIGN;
         OPK_GT:    return OP_GT;
         OPK_LT:    return OP_LT;
         OPK_PLUS:  return OP_ADD;
         OPK_MINUS: return OP_SUB;
         OPK_STAR:  return OP_MUL;
         default:   return OP_DIV;
      endcase
   endfunction

   function automatic void take_char(input logic [7:0] c);
      if (tok_len < PFX_DEPTH) prefix[tok_len] = c;
      if (tok_len < LEN_LIMIT) tok_len++;
   endfunction

   function automatic void close_token(input cst_class_type cls, input logic [4:0] idx);
      cst_result_type w;
      w.token_class  = cls;
      w.token_index  = idx;
      w.token_length = (tok_len > 255) ? 8'hFF : 8'(tok_len);
      w.last_of_run  = 1'b0;
      if (char_words.size() < 2) char_words = {char_words, w};
      scan_st = ST_START;
      tok_len = 0;
   endfunction

   // keyword when the stored prefix spells one of the table entries exactly
   function automatic void close_word();
      string s;
      bit    same;
      for (int k = 0; k < KW_COUNT; k++) begin
         s = keyword_spelling(k);
         if (tok_len == s.len()) begin
            same = 1'b1;
            for (int i = 0; i < s.len(); i++)
               if (prefix[i] != 8'(s[i])) same = 1'b0;
            if (same) begin
               close_token(CL_KEY, 5'(k));
               return;
            end
         end
      end
      close_token(CL_ID, 5'd0);
   endfunction

   function automatic void start_char(input logic [7:0] c);
      int d;
      int k;
      d = delim_index(c);
      k = lead_kind(c);
      if (letter_char(c)) begin
         take_char(c);
         scan_st = ST_WORD;
      end else if (digit_char(c)) begin
         take_char(c);
         scan_st = ST_INT;
      end else if (c == CHR_SQUOTE) begin
         take_char(c);
         scan_st = ST_CHR;
      end else if (c == CHR_DQUOTE) begin
         take_char(c);
         scan_st = ST_STR;
      end else if (k >= 0) begin
         take_char(c);
         op_kind = 3'(k);
         scan_st = ST_OP;
      end else if (d >= 0) begin
         take_char(c);
         close_token(CL_OP, 5'(d));
      end
   endfunction

   // character in a pending token; returns 1 when the character was consumed
   function automatic bit pending_char(input logic [7:0] c);
      logic [7:0] f1;
      logic [7:0] f2;
      logic [4:0] i1;
      logic [4:0] i2;
      bit         f2_ok;
      case (scan_st)
         ST_WORD: begin
            if (letter_char(c) || digit_char(c)) begin
               take_char(c);
               return 1'b1;
            end
            close_word();
            return 1'b0;
         end
         ST_INT: begin
            if (digit_char(c)) begin
               take_char(c);
               return 1'b1;
            end
            if (c == CHR_DOT) begin
               take_char(c);
               scan_st = ST_DOT;
               return 1'b1;
            end
            close_token(CL_NUM, 5'd0);
            return 1'b0;
         end
         ST_DOT: begin
            if (digit_char(c)) begin
               take_char(c);
               scan_st = ST_FRAC;
               return 1'b1;
            end
            // dot with no digit after it: error, offending character dropped
            err_sticky = 1'b1;
            close_token(CL_ERR, 5'd0);
            return 1'b1;
         end
         ST_FRAC: begin
            if (digit_char(c)) begin
               take_char(c);
               return 1'b1;
            end
            close_token(CL_NUM, 5'd0);
            return 1'b0;
         end
         ST_CHR: begin
            take_char(c);
            if (c == CHR_SQUOTE) close_token(CL_CHR, 5'd0);
            return 1'b1;
         end
         ST_STR: begin
            take_char(c);
            if (c == CHR_DQUOTE) close_token(CL_STR, 5'd0);
            return 1'b1;
         end
         ST_OP: begin
            f1    = CHR_EQ;
            f2    = CHR_EQ;
            f2_ok = 1'b0;
            i2    = OP_ADDEQ;
            case (op_kind)
               OPK_EQ:    i1 = OP_EQEQ;
               OPK_GT:    i1 = OP_GE;
               OPK_LT:    i1 = OP_LE;
               OPK_PLUS: begin
                  f1    = CHR_PLUS;
                  i1    = OP_INC;
                  f2_ok = 1'b1;
                  i2    = OP_ADDEQ;
               end
               OPK_MINUS: begin
                  f1    = CHR_MINUS;
                  i1    = OP_DEC;
                  f2_ok = 1'b1;
                  i2    = OP_SUBEQ;
               end
               OPK_STAR:  i1 = OP_MULEQ;
               default:   i1 = OP_DIVEQ;
            endcase
            if (c == f1) begin
               take_char(c);
               close_token(CL_OP, i1);
               return 1'b1;
            end
            if (f2_ok && c == f2) begin
               take_char(c);
               close_token(CL_OP, i2);
               return 1'b1;
            end
            close_token(CL_OP, solo_index(op_kind));
            return 1'b0;
         end
         default: begin
            scan_st = ST_START;
            tok_len = 0;
            return 1'b0;
         end
      endcase
   endfunction

   // end of input: close whatever is pending, quotes and a bare dot are errors
   function automatic void flush_pending();
      case (scan_st)
         ST_START: ;
         ST_WORD:         close_word();
         ST_INT, ST_FRAC: close_token(CL_NUM, 5'd0);
         ST_OP:           close_token(CL_OP, solo_index(op_kind));
         default: begin
            err_sticky = 1'b1;
            close_token(CL_ERR, 5'd0);
         end
      endcase
   endfunction

   function automatic void predict_char(input logic [7:0] c, input logic eoi);
      bit used;
      char_words.delete();
      if (err_sticky) return;
      used = 1'b0;
      if (scan_st != ST_START) used = pending_char(c);
      if (!used && !err_sticky) start_char(c);
      if (eoi && !err_sticky) flush_pending();
      if (eoi) begin
         scan_st = ST_START;
         tok_len = 0;
      end
      if (char_words.size() > 0) char_words[char_words.size() - 1].last_of_run = 1'b1;
      foreach (char_words[i]) token_q = {token_q, char_words[i]};
   endfunction

   // sample both channels at the rising edge
   always @(posedge clock) begin
      cst_result_type want;
      cst_result_type got;
      if (reset) begin
         scan_st    = ST_START;
         op_kind    = OPK_EQ;
         tok_len    = 0;
         err_sticky = 1'b0;
         foreach (prefix[i]) prefix[i] = 8'd0;
         token_q.delete();
      end else begin
         if (req_mon.valid && req_mon.ready)
            predict_char(req_mon.char_in, req_mon.end_of_input);
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.token_class  = rsp_mon.token_class;
            got.token_index  = rsp_mon.token_index;
            got.token_length = rsp_mon.token_length;
            got.last_of_run  = rsp_mon.last_of_run;
            if (token_q.size() == 0) begin
               misses++;
               if (misses <= REPORT_MAX)
                  $display("unexpected token word: class %0d index %0d length %0d last %0b",
                           got.token_class, got.token_index, got.token_length,
                           got.last_of_run);
            end else begin
               want = token_q.pop_front();
               if (got.token_class !== want.token_class ||
                   got.token_index !== want.token_index ||
                   got.token_length !== want.token_length ||
                   got.last_of_run !== want.last_of_run) begin
                  misses++;
                  if (misses <= REPORT_MAX) begin
                     $display("token word %0d mismatch: expected class %0d index %0d %s",
                              checked, want.token_class, want.token_index, "");
                     $display("   expected length %0d last %0b", want.token_length,
                              want.last_of_run);
                     $display("   got class %0d index %0d length %0d last %0b",
                              got.token_class, got.token_index, got.token_length,
                              got.last_of_run);
                  end
               end
               checked++;
            end
         end
      end
      waiting = token_q.size();
   end

endmodule

// ===== tb/sv/tb.sv =====
// token scanner testbench top: clock, reset, character stimulus, result stalls and verdict
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import cst_pkg::*;

   localparam int RANDOM_CHARS = 1000;
   localparam int CALM_FROM    = 900;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int SETTLE       = 20;

   logic clock = 1'b0;
   logic reset = 1'b1;

   cst_req_if req_chan ();
   cst_rsp_if rsp_chan ();

   int fail_count;
   int tokens_waiting;
   int tokens_checked;

   // no idling on either side once set
   bit calm = 1'b0;

   logic [7:0] piece [$];
   int         sent_chars = 0;

   c_subset_token_scanner dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   cst_token_checker scoreboard (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_chan),
      .rsp_mon        (rsp_chan),
      .fail_count     (fail_count),
      .tokens_waiting (tokens_waiting),
      .tokens_checked (tokens_checked)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // run-away guard
   initial begin
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("tb failed");
      $finish;
   end

   // result side drops ready in random bursts until calm is set
   initial begin
      int hold;
      hold = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold > 0) hold--;
         else if (!calm && $urandom_range(0, 5) == 0) hold = $urandom_range(1, 3);
         rsp_chan.ready <= (hold == 0);
      end
   end

   function automatic string keyword_text(input int k);
      case (k)
         0:       return "int";
         1:       return "main";
         2:       return "void";
         3:       return "if";
         4:       return "else";
         5:       return "char";
         6:       return "float";
         7:       return "double";
         8:       return "for";
         9:       return "while";
         10:      return "break";
         11:      return "switch";
         12:      return "case";
         13:      return "default";
         default: return "return";
      endcase
   endfunction

   function automatic logic [7:0] rand_letter();
      if ($urandom_range(0, 1) == 1) return 8'("a" + $urandom_range(0, 25));
      return 8'("A" + $urandom_range(0, 25));
   endfunction

   function automatic logic [7:0] rand_digit();
      return 8'("0" + $urandom_range(0, 9));
   endfunction

   function automatic logic [7:0] rand_alnum();
      if ($urandom_range(0, 3) == 0) return rand_digit();
      return rand_letter();
   endfunction

   // any byte that cannot open a quote or leave a bare dot behind a number
   function automatic logic [7:0] noise_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255));
      while (b == CHR_DOT || b == CHR_SQUOTE || b == CHR_DQUOTE);
      return b;
   endfunction

   function automatic logic [7:0] byte_but(input logic [7:0] banned);
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255));
      while (b == banned);
      return b;
   endfunction

   // mostly short lengths, now and then one near or past the length field's range
   function automatic int rand_span(input int lo, input int hi);
      if ($urandom_range(0, 40) == 0) return $urandom_range(250, 300);
      return $urandom_range(lo, hi);
   endfunction

   // build one well-formed piece of source text; returns 1 unless it is filler
   function automatic bit build_piece();
      string s;
      int    n;
      logic [7:0] q;
      case ($urandom_range(0, 11))
         0, 1: begin
            s = keyword_text($urandom_range(0, KW_COUNT - 1));
            n = $urandom_range(0, 3);
            for (int i = 0; i < s.len(); i++)
               if (!(n == 0 && i == s.len() - 1)) piece = {piece, s[i]};
            if (n == 1) piece = {piece, rand_alnum()};
            return 1'b1;
         end
         2: begin
            piece = {piece, rand_letter()};
            n = rand_span(0, 9);
            repeat (n) piece = {piece, rand_alnum()};
            return 1'b1;
         end
         3: begin
            n = rand_span(1, 6);
            repeat (n) piece = {piece, rand_digit()};
            return 1'b1;
         end
         4: begin
            repeat ($urandom_range(1, 4)) piece = {piece, rand_digit()};
            piece = {piece, CHR_DOT};
            repeat ($urandom_range(1, 4)) piece = {piece, rand_digit()};
            return 1'b1;
         end
         5, 6: begin
            s = "=><+-*/";
            q = s[$urandom_range(0, 6)];
            piece = {piece, q};
            case ($urandom_range(0, 3))
               1: piece = {piece, CHR_EQ};
               2: piece = {piece, q};
               3: piece = {piece, noise_byte()};
               default: ;
            endcase
            return 1'b1;
         end
         7: begin
            s = "{}()[],;";
            piece = {piece, s[$urandom_range(0, 7)]};
            return 1'b1;
         end
         8: begin
            piece = {piece, CHR_SQUOTE};
            repeat ($urandom_range(0, 3)) piece = {piece, byte_but(CHR_SQUOTE)};
            piece = {piece, CHR_SQUOTE};
            return 1'b1;
         end
         9: begin
            piece = {piece, CHR_DQUOTE};
            n = rand_span(0, 12);
            repeat (n) piece = {piece, byte_but(CHR_DQUOTE)};
            piece = {piece, CHR_DQUOTE};
            return 1'b1;
         end
         10: begin
            repeat ($urandom_range(1, 3)) piece = {piece, noise_byte()};
            return 1'b0;
         end
         default: begin
            piece = {piece, (($urandom_range(0, 1) == 1) ? 8'h20 : 8'h0A)};
            return 1'b0;
         end
      endcase
   endfunction

   // one word on the character channel; called and returning at a falling edge
   task automatic send_char(input logic [7:0] c, input logic eoi);
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.char_in      <= c;
      req_chan.end_of_input <= eoi;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      @(negedge clock);
      sent_chars++;
   endtask

   task automatic send_text(input string s, input bit eoi_last);
      for (int i = 0; i < s.len(); i++)
         send_char(s[i], eoi_last && i == s.len() - 1);
   endtask

   task automatic send_piece(input bit eoi_last);
      foreach (piece[i]) send_char(piece[i], eoi_last && i == piece.size() - 1);
   endtask

   // hold the sender off until every token word owed has come out
   task automatic hold_until_drained();
      req_chan.valid <= 1'b0;
      @(negedge clock);
      while (tokens_waiting != 0) @(negedge clock);
   endtask

   initial begin
      int    pieces;
      int    token_chars;
      int    pauses;
      int    tail_kind;
      bit    counted;
      string tail_name;
      pieces      = 0;
      token_chars = 0;
      pauses      = 0;
      req_chan.valid        = 1'b0;
      req_chan.char_in      = 8'd0;
      req_chan.end_of_input = 1'b0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: flushed keyword, extreme operator indexes, one character closing
      // a word and making a delimiter, 0x00 and 0xFF bytes, empty quotes, flushed number
      send_text("int", 1'b1);
      send_text("<=a;", 1'b0);
      send_text("return+=", 1'b0);
      send_char(CHR_SQUOTE, 1'b0);
      send_char(8'hFF, 1'b0);
      send_char(CHR_SQUOTE, 1'b0);
      send_char(8'h00, 1'b0);
      send_char(CHR_DQUOTE, 1'b0);
      send_char(CHR_DQUOTE, 1'b0);
      send_text("9.5", 1'b1);

      // random stream of well-formed pieces with filler between them
      while (token_chars < RANDOM_CHARS) begin
         piece.delete();
         counted = build_piece();
         if (counted) token_chars += piece.size();
         if (token_chars > CALM_FROM) calm = 1'b1;
         send_piece(counted && $urandom_range(0, 9) == 0);
         pieces++;
         if (pieces % 150 == 75) begin
            hold_until_drained();
            pauses++;
         end
      end

      // the error sticks until reset, so it closes the run
      calm = 1'b1;
      send_char(8'h20, 1'b0);
      tail_kind = $urandom_range(0, 2);
      case (tail_kind)
         0: begin
            tail_name = "dot without digit";
            send_text("7.x", 1'b0);
         end
         1: begin
            tail_name = "end inside a char constant";
            send_char(CHR_SQUOTE, 1'b0);
            send_text("ab", 1'b1);
         end
         default: begin
            tail_name = "end after a trailing dot";
            send_text("12.", 1'b1);
         end
      endcase
      send_text("int x;", 1'b1);
      req_chan.valid <= 1'b0;

      while (tokens_waiting != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);

      $display("sent %0d characters (%0d in random pieces), checked %0d token words",
               sent_chars, token_chars, tokens_checked);
      $display("sender drained the scanner %0d times; stream closed on %s",
               pauses, tail_name);
      if (fail_count == 0 && tokens_waiting == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule
